// ===== rtl/yuhb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Yaw unwrap history buffer package
// Shared codes, fixed-point constants and pipeline types.
// ----------------------------------------------------------------------------
package yuhb_pkg;

  // Command codes carried in the cmd field.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Read source codes.
  localparam logic [2:0] SRC_PITCH = 3'd0;
  localparam logic [2:0] SRC_YAW   = 3'd1;
  localparam logic [2:0] SRC_QW    = 3'd2;
  localparam logic [2:0] SRC_QX    = 3'd3;
  localparam logic [2:0] SRC_QY    = 3'd4;
  localparam logic [2:0] SRC_QZ    = 3'd5;

  // Q3.13 wrap thresholds (+/-3.0) and 2*pi.
  localparam logic signed [15:0] WRAP_HI    = 16'sd24576;
  localparam logic signed [15:0] WRAP_LO    = -16'sd24576;
  localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;

  // Read addressing: a 6-bit age splits into a group and a slot in the group.
  localparam int AGE_W    = 6;
  localparam int SLOT_W   = 3;
  localparam int GRP_W    = AGE_W - SLOT_W;
  localparam int AGE_SPAN = 1 << AGE_W;
  localparam int N_GRP    = 1 << GRP_W;

  // Tag that travels with a word from the pick stage to the output register.
  typedef struct packed {
    logic             push;
    logic             ok;
    logic [GRP_W-1:0] grp;
  } rd_tag_t;

endpackage

// ===== rtl/yuhb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Yaw unwrap history buffer channels
// Valid/ready channels for sample words and result words.
// ----------------------------------------------------------------------------
interface yuhb_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [15:0] yaw_angle;
  logic signed [14:0] pitch_angle;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic        [2:0]  source_select;
  logic        [5:0]  age;

  modport source (
    output valid, cmd, yaw_angle, pitch_angle, quat_w, quat_x, quat_y, quat_z,
           source_select, age,
    input  ready
  );
  modport sink (
    input  valid, cmd, yaw_angle, pitch_angle, quat_w, quat_x, quat_y, quat_z,
           source_select, age,
    output ready
  );
endinterface

interface yuhb_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               status;

  modport source (output valid, value, status, input ready);
  modport sink (input valid, value, status, output ready);
endinterface

// ===== rtl/yuhb_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// History cell
// One delay-line entry that takes its neighbor's value on every shift.
// ----------------------------------------------------------------------------
module yuhb_cell #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

// ===== rtl/yuhb_line.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// History line
// A chain of cells plus the first level of the read selection tree.
// ----------------------------------------------------------------------------
module yuhb_line #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 40
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        shift,
  input  logic [WIDTH-1:0]            d,
  input  logic [yuhb_pkg::SLOT_W-1:0] slot,
  output logic [WIDTH-1:0]            pick [yuhb_pkg::N_GRP]
);
  import yuhb_pkg::*;

  logic [WIDTH-1:0] cell_q [DEPTH];
  logic [WIDTH-1:0] tap    [AGE_SPAN];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    yuhb_cell #(.WIDTH(WIDTH)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .d     ((i == 0) ? d : cell_q[(i == 0) ? 0 : i - 1]),
      .q     (cell_q[i])
    );
  end

  // Ages beyond the line read as zero; the range check rejects them anyway.
  for (genvar i = 0; i < AGE_SPAN; i++) begin : g_tap
    if (i < DEPTH) begin : g_live
      assign tap[i] = cell_q[i];
    end else begin : g_pad
      assign tap[i] = '0;
    end
  end

  for (genvar g = 0; g < N_GRP; g++) begin : g_pick
    assign pick[g] = tap[{GRP_W'(g), slot}];
  end

endmodule

// ===== rtl/yuhb_unwrap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Yaw unwrap
// Keeps the last yaw and the saturating unwrapped yaw total.
// ----------------------------------------------------------------------------
module yuhb_unwrap (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic signed [15:0] yaw_angle,
  output logic signed [31:0] total_next,
  output logic signed [31:0] total
);
  import yuhb_pkg::*;

  logic signed [15:0] previous_yaw;
  logic signed [17:0] diff;
  logic signed [17:0] delta;
  logic signed [32:0] sum;

  always_comb begin
    diff = 18'(yaw_angle) - 18'(previous_yaw);
    if ((previous_yaw > WRAP_HI) && (yaw_angle < WRAP_LO)) begin
      delta = diff + TWO_PI_Q13;
    end else if ((previous_yaw < WRAP_LO) && (yaw_angle > WRAP_HI)) begin
      delta = diff - TWO_PI_Q13;
    end else begin
      delta = diff;
    end
    sum = 33'(total) + 33'(delta);
    if (sum[32] != sum[31]) begin
      total_next = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      total_next = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_yaw <= '0;
      total        <= '0;
    end else if (push) begin
      previous_yaw <= yaw_angle;
      total        <= total_next;
    end
  end

endmodule

// ===== rtl/yaw_unwrap_history_buffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Yaw unwrap history buffer
// Unwraps yaw into a running total and keeps delay lines of recent samples.
// ----------------------------------------------------------------------------
// Usage:
// Words arrive on the sample channel. A push word (cmd = 0) updates the
// unwrapped yaw total, shifts every history line by one entry and answers
// with the new total. A read word (cmd = 1) answers with one stored entry,
// chosen by source_select and age, sign-extended to 32 bits; an age beyond
// the line or an unknown source answers status 1 and value 0.
// Every word produces exactly one result word on the result channel.
// A word passes the pick stage, which picks a group of eight entries per
// line, and the output stage, which selects the group and loads the output
// register. Throughput is one word per cycle while the receiver does not
// stall, set by the history cells, which all shift in the same cycle on a push.
// When the receiver stalls, the two stages hold and sample.ready drops as
// soon as the output register is full and not being taken.
// Synchronous reset clears the yaw state and every history cell and empties
// both pipeline stages; the block accepts words as soon as reset is released.
// ----------------------------------------------------------------------------
module yaw_unwrap_history_buffer #(
  parameter int ANGLE_DEPTH = 40,
  parameter int QUAT_DEPTH  = 5
) (
  input  logic        clk,
  input  logic        rst,
  yuhb_in_if.sink     sample,
  yuhb_out_if.source  result
);
  import yuhb_pkg::*;

  logic               advance;
  logic               accept;
  logic               push;
  logic signed [31:0] total_next;
  logic signed [31:0] total;

  logic [31:0] yaw_pick   [N_GRP];
  logic [14:0] pitch_pick [N_GRP];
  logic [15:0] quat_pick  [4][N_GRP];
  logic [15:0] quat_in    [4];

  // Pick stage registers.
  logic        s1_valid;
  rd_tag_t     s1_tag;
  rd_tag_t     s1_tag_next;
  logic [31:0] s1_total;
  logic [31:0] s1_pick      [N_GRP];
  logic [31:0] s1_pick_next [N_GRP];

  // Output register.
  logic        res_valid;
  logic [31:0] res_value;
  logic        res_status;

  // The whole pipeline moves unless a finished word is still waiting.
  // No word is taken while reset is held.
  assign advance      = !res_valid || result.ready;
  assign sample.ready = advance && !rst;
  assign accept       = sample.valid && sample.ready;
  assign push         = accept && (sample.cmd == CMD_PUSH);

  yuhb_unwrap u_unwrap (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .yaw_angle  (sample.yaw_angle),
    .total_next (total_next),
    .total      (total)
  );

  yuhb_line #(.WIDTH(32), .DEPTH(ANGLE_DEPTH)) u_yaw_line (
    .clk   (clk),
    .rst   (rst),
    .shift (push),
    .d     (total_next),
    .slot  (sample.age[SLOT_W-1:0]),
    .pick  (yaw_pick)
  );

  yuhb_line #(.WIDTH(15), .DEPTH(ANGLE_DEPTH)) u_pitch_line (
    .clk   (clk),
    .rst   (rst),
    .shift (push),
    .d     (sample.pitch_angle),
    .slot  (sample.age[SLOT_W-1:0]),
    .pick  (pitch_pick)
  );

  assign quat_in[0] = sample.quat_w;
  assign quat_in[1] = sample.quat_x;
  assign quat_in[2] = sample.quat_y;
  assign quat_in[3] = sample.quat_z;

  for (genvar k = 0; k < 4; k++) begin : g_quat
    yuhb_line #(.WIDTH(16), .DEPTH(QUAT_DEPTH)) u_quat_line (
      .clk   (clk),
      .rst   (rst),
      .shift (push),
      .d     (quat_in[k]),
      .slot  (sample.age[SLOT_W-1:0]),
      .pick  (quat_pick[k])
    );
  end

  // Range check and per-group source selection for a read word.
  always_comb begin
    s1_tag_next.push = (sample.cmd == CMD_PUSH);
    s1_tag_next.grp  = sample.age[AGE_W-1:SLOT_W];
    case (sample.source_select)
      SRC_PITCH, SRC_YAW: begin
        s1_tag_next.ok = int'(sample.age) < ANGLE_DEPTH;
      end
      SRC_QW, SRC_QX, SRC_QY, SRC_QZ: begin
        s1_tag_next.ok = int'(sample.age) < QUAT_DEPTH;
      end
      default: begin
        s1_tag_next.ok = 1'b0;
      end
    endcase
    for (int g = 0; g < N_GRP; g++) begin
      case (sample.source_select)
        SRC_PITCH: s1_pick_next[g] = {{17{pitch_pick[g][14]}}, pitch_pick[g]};
        SRC_YAW:   s1_pick_next[g] = yaw_pick[g];
        SRC_QW:    s1_pick_next[g] = {{16{quat_pick[0][g][15]}}, quat_pick[0][g]};
        SRC_QX:    s1_pick_next[g] = {{16{quat_pick[1][g][15]}}, quat_pick[1][g]};
        SRC_QY:    s1_pick_next[g] = {{16{quat_pick[2][g][15]}}, quat_pick[2][g]};
        SRC_QZ:    s1_pick_next[g] = {{16{quat_pick[3][g][15]}}, quat_pick[3][g]};
        default:   s1_pick_next[g] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= sample.valid;
      res_valid <= s1_valid;
    end
  end

  // Payload registers; the pick stage captures the lines before any later push.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_tag   <= s1_tag_next;
      s1_total <= total_next;
      s1_pick  <= s1_pick_next;
      if (s1_tag.push) begin
        res_value  <= s1_total;
        res_status <= 1'b0;
      end else if (s1_tag.ok) begin
        res_value  <= s1_pick[s1_tag.grp];
        res_status <= 1'b0;
      end else begin
        res_value  <= '0;
        res_status <= 1'b1;
      end
    end
  end

  assign result.valid  = res_valid;
  assign result.value  = res_value;
  assign result.status = res_status;

  // A push leaves the new total both in the unwrap state and in the pick stage.
  a_push_total : assert property (@(posedge clk) disable iff (rst)
    push |=> s1_valid && s1_tag.push && (s1_total == total))
    else $error("push total not carried into pick stage");

  // A rejected read always answers zero.
  a_reject_zero : assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status |-> result.value == '0)
    else $error("rejected read with nonzero value");

  // A stalled output with a word behind it must block new samples.
  a_stall_blocks : assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !sample.ready)
    else $error("sample accepted while output stalled");

  // A word in the pick stage reaches the output register on the next advance.
  a_stage_flow : assert property (@(posedge clk) disable iff (rst)
    s1_valid && advance |=> res_valid)
    else $error("word lost between pick stage and output");

endmodule
